// ===== rtl/fdms_pkg.sv =====
// fdms_pkg: shared constants and types of the frame-difference motion silhouette core.
// No dependencies; imported by all rtl modules but fdms_ram and fdms_checker.
package fdms_pkg;

	localparam int LINE_PIXELS = 1024;
	localparam int LINES       = 1024;

	localparam int MASK_AW    = 20;
	localparam int MASK_DEPTH = 1 << MASK_AW;
	localparam int FRAME_PIX  = LINE_PIXELS * LINES;
	localparam int FRAME_CAP  = (FRAME_PIX < MASK_DEPTH) ? FRAME_PIX : MASK_DEPTH;

	localparam logic [MASK_AW-1:0] ADDR_LAST = MASK_AW'(FRAME_CAP - 1);
	localparam logic [MASK_AW-1:0] CLR_LAST  = MASK_AW'(MASK_DEPTH - 1);

	localparam int PIX_W = 8;
	localparam logic [PIX_W-1:0] THRESH_RESET = 8'd15;

	// APB register map
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [0:0] REG_THRESHOLD = 1'b0;

	// output queue
	localparam int OFIFO_AW    = 2;
	localparam int OFIFO_DEPTH = 1 << OFIFO_AW;

	typedef struct packed {
		logic valid;
		logic change;
		logic line_last;
		logic frame_last;
	} px_t;

	typedef struct packed {
		logic change_bit;
		logic eroded_bit;
		logic silhouette_bit;
		logic line_end;
		logic frame_end;
	} res_t;

	typedef struct packed {
		logic push0;
		logic push1;
		res_t res0;
		res_t res1;
	} push_t;

endpackage

// ===== rtl/fdms_ram.sv =====
// fdms_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fdms_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/fdms_cfg.sv =====
// fdms_cfg: APB register block holding the pixel threshold.
// Depends on fdms_pkg.
module fdms_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fdms_pkg::APB_AW-1:0]       paddr,
	input  logic [fdms_pkg::APB_DW-1:0]       pwdata,
	output logic [fdms_pkg::APB_DW-1:0]       prdata,
	output logic                              pready,
	output logic [fdms_pkg::PIX_W-1:0]        threshold
);
	import fdms_pkg::*;

	logic [PIX_W-1:0] threshold_q;
	logic             wr_en;
	logic             sel_thr;

	assign pready  = 1'b1;
	assign sel_thr = (paddr[APB_AW-1:2] == REG_THRESHOLD);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RESET;
		end else if (wr_en && sel_thr) begin
			threshold_q <= pwdata[PIX_W-1:0];
		end
	end

	assign prdata    = sel_thr ? APB_DW'(threshold_q) : '0;
	assign threshold = threshold_q;

endmodule

// ===== rtl/fdms_mask.sv =====
// fdms_mask: input register, frame-mask address counter, mask RAM with clear sweep,
// and change-bit generation. Depends on fdms_pkg and fdms_ram.
module fdms_mask (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [fdms_pkg::PIX_W-1:0] pixel,
	input  logic                       last_in_line,
	input  logic                       last_in_frame,
	input  logic [fdms_pkg::PIX_W-1:0] threshold,
	input  logic                       fire,
	output fdms_pkg::px_t              px
);
	import fdms_pkg::*;

	logic               clr_busy_q;
	logic [MASK_AW-1:0] clr_addr_q;
	logic [MASK_AW-1:0] pixel_address_q;

	logic               valid_s1;
	logic [PIX_W-1:0]   pixel_s1;
	logic               lend_s1;
	logic               fend_s1;
	logic [MASK_AW-1:0] addr_s1;
	logic               fwd_hit_s1;
	logic               fwd_data_s1;

	logic               accept;
	logic               mask;
	logic               old_mask;
	logic               ram_we;
	logic [MASK_AW-1:0] ram_waddr;
	logic               ram_wdata;
	logic               ram_rdata;

	assign in_stall = clr_busy_q || (valid_s1 && !fire);
	assign accept   = in_valid && !in_stall;

	assign mask     = (pixel_s1 >= threshold);
	assign old_mask = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;

	assign ram_we    = clr_busy_q || fire;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? 1'b0 : mask;

	fdms_ram #(
		.WIDTH (1),
		.DEPTH (MASK_DEPTH)
	) u_mask_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (pixel_address_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == CLR_LAST)
				clr_busy_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_address_q <= '0;
			valid_s1        <= 1'b0;
			fwd_hit_s1      <= 1'b0;
		end else begin
			if (accept) begin
				if (last_in_frame || pixel_address_q == ADDR_LAST)
					pixel_address_q <= '0;
				else
					pixel_address_q <= pixel_address_q + 1'b1;
				valid_s1   <= 1'b1;
				// write of the same address at this edge is not seen by the RAM read
				fwd_hit_s1 <= fire && (addr_s1 == pixel_address_q);
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1    <= pixel;
			lend_s1     <= last_in_line;
			fend_s1     <= last_in_frame;
			addr_s1     <= pixel_address_q;
			fwd_data_s1 <= mask;
		end
	end

	assign px.valid      = valid_s1;
	assign px.change     = mask ^ old_mask;
	assign px.line_last  = lend_s1;
	assign px.frame_last = fend_s1;

endmodule

// ===== rtl/fdms_shape.sv =====
// fdms_shape: three-wide horizontal erosion and run-edge toggle; forms up to two
// results per pixel. Depends on fdms_pkg.
module fdms_shape (
	input  logic            clk,
	input  logic            arst_n,
	input  fdms_pkg::px_t   px,
	input  logic            fire,
	output fdms_pkg::push_t push
);
	import fdms_pkg::*;

	logic held_valid_q;
	logic held_change_q;
	logic before_held_q;
	logic held_fend_q;
	logic in_zone_q;

	logic ero0;
	logic ero1;
	logic left;
	logic zone_mid;
	res_t r0;
	res_t r1;

	always_comb begin
		ero0     = before_held_q & held_change_q & px.change;
		left     = held_valid_q ? held_change_q : 1'b1;
		zone_mid = held_valid_q ? ero0 : in_zone_q;
		ero1     = left & px.change;

		r0.change_bit     = held_change_q;
		r0.eroded_bit     = ero0;
		r0.silhouette_bit = ero0 ^ in_zone_q;
		r0.line_end       = 1'b0;
		r0.frame_end      = held_fend_q;

		r1.change_bit     = px.change;
		r1.eroded_bit     = ero1;
		r1.silhouette_bit = ero1 ^ zone_mid;
		r1.line_end       = 1'b1;
		r1.frame_end      = px.frame_last;
	end

	assign push.push0 = fire && (held_valid_q || px.line_last);
	assign push.push1 = fire && held_valid_q && px.line_last;
	assign push.res0  = held_valid_q ? r0 : r1;
	assign push.res1  = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q  <= 1'b0;
			held_change_q <= 1'b0;
			before_held_q <= 1'b1;
			held_fend_q   <= 1'b0;
			in_zone_q     <= 1'b0;
		end else if (fire) begin
			if (px.line_last) begin
				held_valid_q  <= 1'b0;
				held_change_q <= 1'b0;
				before_held_q <= 1'b1;
				held_fend_q   <= 1'b0;
				in_zone_q     <= 1'b0;
			end else begin
				held_valid_q  <= 1'b1;
				held_change_q <= px.change;
				before_held_q <= left;
				held_fend_q   <= px.frame_last;
				in_zone_q     <= zone_mid;
			end
		end
	end

endmodule

// ===== rtl/fdms_ofifo.sv =====
// fdms_ofifo: small result queue, up to two writes and one read per cycle.
// Depends on fdms_pkg.
module fdms_ofifo (
	input  logic            clk,
	input  logic            arst_n,
	input  fdms_pkg::push_t push,
	output logic            room2,
	output logic            out_valid,
	input  logic            out_stall,
	output fdms_pkg::res_t  head
);
	import fdms_pkg::*;

	res_t                mem_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0] wr_ptr_q;
	logic [OFIFO_AW-1:0] rd_ptr_q;
	logic [OFIFO_AW:0]   count_q;
	logic                pop;
	logic [OFIFO_AW-1:0] wr_ptr_p1;
	logic [OFIFO_AW:0]   n_push;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign room2     = (count_q <= (OFIFO_AW+1)'(OFIFO_DEPTH - 2));
	assign head      = mem_q[rd_ptr_q];
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign n_push    = (OFIFO_AW+1)'(push.push0) + (OFIFO_AW+1)'(push.push1);

	always_ff @(posedge clk) begin
		if (push.push0)
			mem_q[wr_ptr_q] <= push.res0;
		if (push.push1)
			mem_q[wr_ptr_p1] <= push.res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[OFIFO_AW-1:0];
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + n_push - (OFIFO_AW+1)'(pop);
		end
	end

endmodule

// ===== rtl/frame_diff_motion_silhouette_core.sv =====
// frame_diff_motion_silhouette_core: top level of the motion silhouette pipeline.
// Depends on fdms_pkg, fdms_cfg, fdms_mask, fdms_shape, fdms_ofifo.
//
//   channel  handshake           payload
//   -------  ------------------  ---------------------------------------------------
//   in       in_valid/in_stall   pixel, last_in_line, last_in_frame
//   out      out_valid/out_stall change_bit, eroded_bit, silhouette_bit, line_end,
//                                frame_end
//   cfg      APB psel/penable    paddr, pwdata, prdata, pready (threshold at 0x0)
//
// One pixel per cycle unless in_stall is high; a result is queued as its right neighbor fires.
// The mask RAM is read into a register on accept, ahead of the compare, and written back as the pixel fires.
// After reset a clear sweep zeroes the 2^20-entry mask RAM, one entry per cycle,
// and in_stall stays high until the sweep ends; APB writes are taken meanwhile.
// A four-entry result queue absorbs the two results of a line end; out_stall
// backs up into in_stall only once the queue holds more than two results.
module frame_diff_motion_silhouette_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fdms_pkg::APB_AW-1:0] paddr,
	input  logic [fdms_pkg::APB_DW-1:0] pwdata,
	output logic [fdms_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fdms_pkg::PIX_W-1:0]  pixel,
	input  logic                        last_in_line,
	input  logic                        last_in_frame,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        change_bit,
	output logic                        eroded_bit,
	output logic                        silhouette_bit,
	output logic                        line_end,
	output logic                        frame_end
);
	import fdms_pkg::*;

	logic [PIX_W-1:0] threshold;
	px_t              px;
	push_t            push;
	res_t             head;
	logic             room2;
	logic             fire;

	assign fire = px.valid && room2;

	fdms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	fdms_mask u_mask (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel         (pixel),
		.last_in_line  (last_in_line),
		.last_in_frame (last_in_frame),
		.threshold     (threshold),
		.fire          (fire),
		.px            (px)
	);

	fdms_shape u_shape (
		.clk    (clk),
		.arst_n (arst_n),
		.px     (px),
		.fire   (fire),
		.push   (push)
	);

	fdms_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign change_bit     = head.change_bit;
	assign eroded_bit     = head.eroded_bit;
	assign silhouette_bit = head.silhouette_bit;
	assign line_end       = head.line_end;
	assign frame_end      = head.frame_end;

endmodule

// ===== rtl/fdms_checker.sv =====
// fdms_checker: port-level assertions for frame_diff_motion_silhouette_core, with bind.
// Depends on the top level's port list.
module fdms_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic last_in_line,
	input logic out_valid,
	input logic out_stall,
	input logic change_bit,
	input logic eroded_bit,
	input logic silhouette_bit,
	input logic line_end,
	input logic frame_end
);

	logic       in_xfer;
	logic       out_xfer;
	logic [2:0] pend_q;
	logic       prev_ero_q;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// line ends accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			prev_ero_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 3'(in_xfer && last_in_line) - 3'(out_xfer && line_end);
			if (out_xfer)
				prev_ero_q <= line_end ? 1'b0 : eroded_bit;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({change_bit, eroded_bit,
			silhouette_bit, line_end, frame_end}))
		else $error("output transfer changed while stalled");

	a_ero_in_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (!eroded_bit || change_bit))
		else $error("eroded bit set without change bit");

	a_sil_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (silhouette_bit == (eroded_bit ^ prev_ero_q)))
		else $error("silhouette bit does not mark an eroded run edge");

	a_line_end_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && line_end |-> (pend_q != '0))
		else $error("line end delivered before its last pixel was accepted");

endmodule

bind frame_diff_motion_silhouette_core fdms_checker u_fdms_checker (.*);
